// ===== hw/rtl/text_console_char_writer_core_macros.svh =====
// Assertion helpers for the checker file.
`ifndef TEXT_CONSOLE_CHAR_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_CHAR_WRITER_CORE_MACROS_SVH

// Same-cycle implication.
`define TCCW_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("console port check failed");

// Next-cycle implication.
`define TCCW_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("console port check failed");

`endif

// ===== hw/rtl/tccw_pkg.sv =====
package tccw_pkg;

   localparam int KIND_W   = 2;
   localparam int CHAR_W   = 8;
   localparam int ATTR_W   = 8;
   localparam int INDEX_W  = 11;
   localparam int COL_W    = 7;
   localparam int ROW_W    = 5;
   localparam int OFFSET_W = 11;

   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
   localparam logic [ATTR_W-1:0] CLEAR_ATTR = 8'd7;
   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUT    = 2'd0,
      KIND_DELETE = 2'd1,
      KIND_CLEAR  = 2'd2,
      KIND_READ   = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [CHAR_W-1:0]     char_code;
      logic [INDEX_W-1:0]    cell_index;
   } req_type;

   typedef struct packed {
      logic [COL_W-1:0]      cursor_col;
      logic [ROW_W-1:0]      cursor_row;
      logic [OFFSET_W-1:0]   cursor_offset;
      logic                  scrolled;
      logic [CHAR_W-1:0]     cell_char;
      logic [ATTR_W-1:0]     cell_attr;
   } rsp_type;

   typedef logic [ATTR_W-1:0] csr_type;

   typedef struct packed {
      logic [CHAR_W-1:0] glyph;
      logic [ATTR_W-1:0] attr;
   } cell_type;

   typedef struct packed {
      logic home;
      logic step;
      logic line;
      logic back;
   } cur_cmd_type;

   typedef struct packed {
      logic last_col;
      logic last_row;
   } cur_flag_type;

endpackage

// ===== hw/rtl/tccw_chan_if.sv =====
interface tccw_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tccw_screen_ram.sv =====
module tccw_screen_ram import tccw_pkg::*; #(
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  cell_type                 wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output cell_type                 rd_data
);

   cell_type mem [DEPTH];
   cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/tccw_cursor.sv =====
module tccw_cursor import tccw_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                             clock,
   input  logic                             reset,
   input  cur_cmd_type                      cmd,
   output logic [$clog2(COLUMNS)-1:0]       col,
   output logic [$clog2(ROWS)-1:0]          row,
   output logic [$clog2(COLUMNS*ROWS)-1:0]  offset,
   output cur_flag_type                     flags
);

   localparam int XW = $clog2(COLUMNS);
   localparam int YW = $clog2(ROWS);
   localparam int AW = $clog2(COLUMNS * ROWS);
   localparam logic [XW-1:0] LAST_COL = XW'(COLUMNS - 1);
   localparam logic [YW-1:0] LAST_ROW = YW'(ROWS - 1);

   logic [XW-1:0] x_ff, x_in;
   logic [YW-1:0] y_ff, y_in;

   assign flags.last_col = (x_ff == LAST_COL);
   assign flags.last_row = (y_ff == LAST_ROW);

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      priority if (cmd.home) begin
         x_in = '0;
         y_in = '0;
      end else if (cmd.step && !flags.last_col) begin
         x_in = x_ff + 1'b1;
      end else if (cmd.step || cmd.line) begin
         // wrap to the next line; the last row stays put and scrolls
         x_in = '0;
         if (!flags.last_row) begin
            y_in = y_ff + 1'b1;
         end
      end else if (cmd.back) begin
         if (x_ff == '0) begin
            if (y_ff != '0) begin
               y_in = y_ff - 1'b1;
               x_in = LAST_COL;
            end
         end else begin
            x_in = x_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0;
         y_ff <= '0;
      end else begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

   assign col    = x_ff;
   assign row    = y_ff;
   assign offset = AW'(32'(y_ff) * COLUMNS + 32'(x_ff));

endmodule

// ===== hw/rtl/text_console_char_writer_core.sv =====
// Text-mode console writer: one COLUMNS x ROWS screen of character/attribute cells held in a
// single-port-write, single-port-read RAM, plus a cursor. Each request returns exactly one
// response carrying the cursor after the request. A printable put, newline or read goes from
// acceptance through S_DONE into the response register, a delete through S_ERASE and S_DONE;
// S_DONE holds while an earlier response is not yet taken. A put or newline that scrolls walks
// the RAM once, copying each row up one line in a read-then-write pipeline at one cell per
// cycle; clear rewrites every cell at one cell per cycle. After reset a clearing pass fills the
// RAM with spaces of attribute 7 before the first request is taken; the attribute register can
// be written at any time. A new request is taken while the previous response still waits.
module text_console_char_writer_core import tccw_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   tccw_chan_if.sink   req_if,
   tccw_chan_if.source rsp_if,
   tccw_chan_if.sink   csr_if
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int XW    = $clog2(COLUMNS);
   localparam int YW    = $clog2(ROWS);
   localparam int AW    = $clog2(CELLS);
   localparam logic [AW-1:0] LAST_CELL     = AW'(CELLS - 1);
   localparam logic [AW-1:0] LAST_ROW_BASE = AW'(CELLS - COLUMNS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_WIPE,
      S_SCROLL,
      S_ERASE,
      S_DONE
   } state_type;

   state_type     state_ff;
   logic [AW-1:0] sweep_ff;
   logic          reply_ff;
   logic          pend_ff;
   logic [AW-1:0] pend_addr_ff;
   logic          pend_blank_ff;
   kind_type      kind_ff;
   logic          rd_ok_ff;
   logic          scrolled_ff;
   logic [ATTR_W-1:0] attr_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;

   logic          accept;
   logic          is_newline;
   logic          scroll_go;
   cur_cmd_type   cmd;
   cur_flag_type  flags;
   logic [XW-1:0] col;
   logic [YW-1:0] row;
   logic [AW-1:0] offset;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   cell_type      wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   cell_type      rd_data;
   logic          in_body;
   logic [AW-1:0] scroll_addr;

   assign req_if.ready = (state_ff == S_IDLE);
   assign csr_if.ready = 1'b1;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

   assign accept     = req_if.valid && req_if.ready;
   assign is_newline = (req_if.data.char_code == CH_NEWLINE) ||
                       (req_if.data.char_code == CH_RETURN);

   assign cmd.home = accept && (req_if.data.kind == KIND_CLEAR);
   assign cmd.step = accept && (req_if.data.kind == KIND_PUT) && !is_newline;
   assign cmd.line = accept && (req_if.data.kind == KIND_PUT) && is_newline;
   assign cmd.back = accept && (req_if.data.kind == KIND_DELETE);

   assign scroll_go = (cmd.step && flags.last_col && flags.last_row) ||
                      (cmd.line && flags.last_row);

   tccw_cursor #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_cursor (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .col    (col),
      .row    (row),
      .offset (offset),
      .flags  (flags)
   );

   // scroll: body rows read one row down, the last row reads itself and gets blanked
   assign in_body     = (sweep_ff < LAST_ROW_BASE);
   assign scroll_addr = in_body ? AW'(32'(sweep_ff) + COLUMNS) : sweep_ff;

   assign rd_en   = (state_ff == S_SCROLL) || (accept && (req_if.data.kind == KIND_READ));
   assign rd_addr = (state_ff == S_SCROLL) ? scroll_addr : AW'(req_if.data.cell_index);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = offset;
      wr_data = '{glyph: CH_SPACE, attr: attr_ff};
      priority if (pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = pend_addr_ff;
         wr_data = '{glyph: (pend_blank_ff ? CH_SPACE : rd_data.glyph), attr: rd_data.attr};
      end else if (state_ff == S_WIPE) begin
         wr_en   = 1'b1;
         wr_addr = sweep_ff;
         wr_data = '{glyph: CH_SPACE, attr: CLEAR_ATTR};
      end else if (state_ff == S_ERASE) begin
         wr_en   = 1'b1;
      end else if (cmd.step) begin
         wr_en   = 1'b1;
         wr_data = '{glyph: req_if.data.char_code, attr: attr_ff};
      end
   end

   tccw_screen_ram #(
      .DEPTH (CELLS)
   ) u_screen_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_WIPE;
         sweep_ff     <= '0;
         reply_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         attr_ff      <= ATTR_RESET;
      end else begin
         pend_ff <= (state_ff == S_SCROLL);
         if (csr_if.valid) begin
            attr_ff <= csr_if.data;
         end
         if ((state_ff == S_DONE) && (!rsp_valid_ff || rsp_if.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  kind_ff     <= req_if.data.kind;
                  rd_ok_ff    <= (32'(req_if.data.cell_index) < CELLS);
                  scrolled_ff <= scroll_go;
                  sweep_ff    <= '0;
                  reply_ff    <= 1'b1;
                  unique case (req_if.data.kind)
                     KIND_PUT:    state_ff <= scroll_go ? S_SCROLL : S_DONE;
                     KIND_DELETE: state_ff <= S_ERASE;
                     KIND_CLEAR:  state_ff <= S_WIPE;
                     KIND_READ:   state_ff <= S_DONE;
                  endcase
               end
            end
            S_WIPE: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (sweep_ff == LAST_CELL) begin
                  state_ff <= reply_ff ? S_DONE : S_IDLE;
               end
            end
            S_SCROLL: begin
               pend_addr_ff  <= sweep_ff;
               pend_blank_ff <= !in_body;
               sweep_ff      <= sweep_ff + 1'b1;
               if (sweep_ff == LAST_CELL) begin
                  state_ff <= S_DONE;
               end
            end
            S_ERASE: begin
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_if.ready) begin
                  rsp_data_ff.cursor_col      <= COL_W'(col);
                  rsp_data_ff.cursor_row      <= ROW_W'(row);
                  rsp_data_ff.cursor_offset   <= OFFSET_W'(offset);
                  rsp_data_ff.scrolled        <= scrolled_ff;
                  if ((kind_ff == KIND_READ) && rd_ok_ff) begin
                     rsp_data_ff.cell_char <= rd_data.glyph;
                     rsp_data_ff.cell_attr <= rd_data.attr;
                  end else begin
                     rsp_data_ff.cell_char <= '0;
                     rsp_data_ff.cell_attr <= '0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== hw/rtl/tccw_checker.sv =====
`include "text_console_char_writer_core_macros.svh"

module tccw_checker import tccw_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   `TCCW_ASSERT_NXT(a_busy_after_request, clock, reset, req_valid && req_ready, !req_ready)
   `TCCW_ASSERT_IMP(a_busy_before_response, clock, reset, $rose(rsp_valid), $past(!req_ready))
   `TCCW_ASSERT_IMP(a_wipe_after_reset, clock, reset, $past(reset), !req_ready)
   `TCCW_ASSERT_NXT(a_response_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

endmodule

bind text_console_char_writer_core tccw_checker u_tccw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_data  (rsp_if.data)
);

// ===== tb/tb_text_console_char_writer_core.sv =====
`timescale 1ns / 100ps

module tb_text_console_char_writer_core;
   import tccw_pkg::*;

   localparam int COLS   = 80;
   localparam int ROWS   = 25;
   localparam int CELLS  = COLS * ROWS;
   localparam int ITEMS  = 1150;
   localparam int PHASES = 4;
   localparam int LIMIT  = (ITEMS + 100) * (CELLS + 100) * 4;

   logic clock = 1'b0;
   logic reset;

   tccw_chan_if #(.payload_type(req_type)) req_if ();
   tccw_chan_if #(.payload_type(rsp_type)) rsp_if ();
   tccw_chan_if #(.payload_type(csr_type)) csr_if ();

   text_console_char_writer_core #(.COLUMNS(COLS), .ROWS(ROWS)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   logic [CHAR_W-1:0] glyph_mem [CELLS];
   logic [ATTR_W-1:0] attr_mem [CELLS];
   int                cur_col;
   int                cur_row;
   logic [ATTR_W-1:0] text_attr;

   req_type console_ops [$];
   rsp_type console_reports [$];
   int      ops_queued   = 0;
   int      reports_seen = 0;
   int      mismatches   = 0;
   int      cycles       = 0;
   logic    req_taken    = 1'b0;
   logic    calm         = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void wipe_screen();
      for (int i = 0; i < CELLS; i++) begin
         glyph_mem[i] = CH_SPACE;
         attr_mem[i]  = CLEAR_ATTR;
      end
      cur_col = 0;
      cur_row = 0;
   endfunction

   function automatic void scroll_screen();
      for (int i = 0; i < CELLS - COLS; i++) begin
         glyph_mem[i] = glyph_mem[i + COLS];
         attr_mem[i]  = attr_mem[i + COLS];
      end
      for (int i = CELLS - COLS; i < CELLS; i++)
         glyph_mem[i] = CH_SPACE;
   endfunction

   function automatic logic advance_line();
      cur_col = 0;
      if (cur_row == ROWS - 1) begin
         scroll_screen();
         return 1'b1;
      end
      cur_row++;
      return 1'b0;
   endfunction

   function automatic rsp_type console_apply(req_type op);
      rsp_type r;
      int      pos;
      r   = '0;
      pos = cur_row * COLS + cur_col;
      case (op.kind)
         KIND_PUT: begin
            if (op.char_code == CH_NEWLINE || op.char_code == CH_RETURN) begin
               r.scrolled = advance_line();
            end else begin
               glyph_mem[pos] = op.char_code;
               attr_mem[pos]  = text_attr;
               if (cur_col == COLS - 1)
                  r.scrolled = advance_line();
               else
                  cur_col++;
            end
         end
         KIND_DELETE: begin
            if (cur_col > 0) begin
               cur_col--;
            end else if (cur_row > 0) begin
               cur_row--;
               cur_col = COLS - 1;
            end
            pos = cur_row * COLS + cur_col;
            glyph_mem[pos] = CH_SPACE;
            attr_mem[pos]  = text_attr;
         end
         KIND_CLEAR: begin
            wipe_screen();
         end
         default: begin
            if (op.cell_index < CELLS) begin
               r.cell_char = glyph_mem[op.cell_index];
               r.cell_attr = attr_mem[op.cell_index];
            end
         end
      endcase
      r.cursor_col    = COL_W'(cur_col);
      r.cursor_row    = ROW_W'(cur_row);
      r.cursor_offset = OFFSET_W'(cur_row * COLS + cur_col);
      return r;
   endfunction

   task automatic compare_report(input rsp_type want, input rsp_type got);
      string bad;
      bad = "";
      if (got.cursor_col !== want.cursor_col) bad = {bad, " cursor_col"};
      if (got.cursor_row !== want.cursor_row) bad = {bad, " cursor_row"};
      if (got.cursor_offset !== want.cursor_offset) bad = {bad, " cursor_offset"};
      if (got.scrolled !== want.scrolled) bad = {bad, " scrolled"};
      if (got.cell_char !== want.cell_char) bad = {bad, " cell_char"};
      if (got.cell_attr !== want.cell_attr) bad = {bad, " cell_attr"};
      if (bad != "") begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: mismatch in%s: exp col %0d row %0d off %0d scr %0b chr %h att %h",
                     $time, bad, want.cursor_col, want.cursor_row, want.cursor_offset,
                     want.scrolled, want.cell_char, want.cell_attr);
         if (mismatches <= 10)
            $display("%0t:   got col %0d row %0d off %0d scr %0b chr %h att %h",
                     $time, got.cursor_col, got.cursor_row, got.cursor_offset,
                     got.scrolled, got.cell_char, got.cell_attr);
      end
   endtask

   always @(posedge clock) begin
      req_taken <= req_if.valid && req_if.ready;
      if (!reset) begin
         if (csr_if.valid && csr_if.ready)
            text_attr = csr_if.data;
         if (req_if.valid && req_if.ready)
            console_reports.push_back(console_apply(req_if.data));
         if (rsp_if.valid && rsp_if.ready) begin
            if (console_reports.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: response with no request outstanding", $time);
            end else begin
               compare_report(console_reports.pop_front(), rsp_if.data);
               reports_seen <= reports_seen + 1;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (console_ops.size() > 0 && (calm || $urandom_range(0, 99) >= 30)) begin
            req_if.data  <= console_ops.pop_front();
            req_if.valid <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
      rsp_if.ready <= calm || ($urandom_range(0, 99) >= 30);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("tb_text_console_char_writer_core: done, errors");
         $finish;
      end
   end

   task automatic queue_op(input kind_type kind, input int code, input int index);
      req_type op;
      op.kind       = kind;
      op.char_code  = CHAR_W'(code);
      op.cell_index = INDEX_W'(index);
      console_ops.push_back(op);
      ops_queued++;
   endtask

   task automatic queue_random(input int count);
      int stop;
      int pick;
      stop = ops_queued + count;
      while (ops_queued < stop) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            repeat ($urandom_range(0, 100))
               queue_op(KIND_PUT, $urandom_range(0, 255), $urandom_range(0, 2047));
            if ($urandom_range(0, 4) != 0)
               queue_op(KIND_PUT, $urandom_range(0, 1) ? CH_NEWLINE : CH_RETURN, 0);
         end else if (pick < 55) begin
            repeat ($urandom_range(1, 30))
               queue_op(KIND_PUT, $urandom_range(0, 1) ? CH_NEWLINE : CH_RETURN, 0);
         end else if (pick < 75) begin
            repeat ($urandom_range(1, 8))
               queue_op(KIND_READ, $urandom_range(0, 255),
                        ($urandom_range(0, 7) == 0) ? $urandom_range(CELLS, 2047)
                                                    : $urandom_range(0, CELLS - 1));
         end else if (pick < 87) begin
            repeat ($urandom_range(1, 90))
               queue_op(KIND_DELETE, $urandom_range(0, 255), $urandom_range(0, 2047));
         end else if (pick < 97) begin
            repeat ($urandom_range(1, 10))
               queue_op(kind_type'($urandom_range(0, 3)), $urandom_range(0, 255),
                        $urandom_range(0, 2047));
         end else begin
            queue_op(KIND_CLEAR, $urandom_range(0, 255), $urandom_range(0, 2047));
         end
      end
   endtask

   task automatic write_text_attr(input csr_type value);
      @(negedge clock);
      csr_if.data  <= value;
      csr_if.valid <= 1'b1;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      @(negedge clock);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (reports_seen != ops_queued) @(posedge clock);
   endtask

   initial begin
      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.data  = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.data  = '0;
      text_attr    = ATTR_RESET;
      wipe_screen();

      queue_op(KIND_READ, 0, 0);
      queue_op(KIND_DELETE, 0, 0);
      queue_op(KIND_READ, 0, 0);
      queue_op(KIND_PUT, 8'h00, 0);
      queue_op(KIND_PUT, 8'hFF, 11'h7FF);
      queue_op(KIND_PUT, 8'h55, 0);
      queue_op(KIND_PUT, 8'hAA, 0);
      queue_op(KIND_READ, 0, 0);
      queue_op(KIND_READ, 0, 1);
      queue_op(KIND_READ, 0, 3);
      queue_op(KIND_DELETE, 0, 0);
      queue_op(KIND_PUT, CH_NEWLINE, 0);
      queue_op(KIND_PUT, CH_RETURN, 0);
      queue_op(KIND_DELETE, 0, 0);
      queue_op(KIND_READ, 0, 2 * COLS - 1);
      queue_op(KIND_READ, 0, CELLS - 1);
      queue_op(KIND_READ, 0, CELLS);
      queue_op(KIND_READ, 8'hFF, 2047);
      queue_op(KIND_READ, 0, 1024);
      queue_op(KIND_CLEAR, 0, 0);
      queue_op(KIND_READ, 0, 0);
      queue_op(KIND_READ, 0, 2 * COLS - 1);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         write_text_attr((p == 0) ? 8'hFF :
                         (p == 1) ? 8'h00 :
                         (p == 2) ? csr_type'($urandom_range(1, 254)) : 8'hA5);
         calm = (p == 1);
         queue_random(ITEMS / PHASES);
      end
      wait_drained();
      repeat (CELLS + 50) @(posedge clock);

      if (mismatches == 0 && console_reports.size() == 0)
         $display("tb_text_console_char_writer_core: done, clean");
      else
         $display("tb_text_console_char_writer_core: done, errors");
      $finish;
   end

endmodule
